[rtl/core/azr_pkg.sv]
// Shared types, constants and tables for the azimuth root finder.
// No dependencies; azr_ctrl, azr_datapath and the top level import this package.
package azr_pkg;

  localparam int ANG_BITS      = 20;         // fraction bits of degrees inside the rotator
  localparam int CORDIC_STEPS  = 24;
  localparam int CORDIC_GAIN   = 652032874;  // 1/K in Q.30
  localparam int DEG_TO_RAD    = 18740330;   // pi/180 in Q.30

  localparam int AW   = 28;   // angles, steps and bracket ends
  localparam int CW   = 34;   // cos, sin and their products, Q.30
  localparam int VW   = 36;   // f, derivative terms
  localparam int MW   = 36;   // multiplier operand width
  localparam int PW   = 2 * MW;
  localparam int DVW  = 64;   // divider remainder
  localparam int QB   = 28;   // quotient bits of the Newton step
  localparam int CNTW = 5;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_NOSIGN  = 2'd1;
  localparam logic [1:0] ST_LIMIT   = 2'd2;

  // multiply sequence; at step k the product of step k-1 is accumulated
  localparam logic [CNTW-1:0] MS_C_C     = 5'd0;
  localparam logic [CNTW-1:0] MS_S_S     = 5'd1;
  localparam logic [CNTW-1:0] MS_C_S     = 5'd2;
  localparam logic [CNTW-1:0] MS_A0_CC   = 5'd3;
  localparam logic [CNTW-1:0] MS_A1_SS   = 5'd4;
  localparam logic [CNTW-1:0] MS_A2_CS   = 5'd5;
  localparam logic [CNTW-1:0] MS_A3_C    = 5'd6;
  localparam logic [CNTW-1:0] MS_A4_S    = 5'd7;
  localparam logic [CNTW-1:0] MS_A2_D    = 5'd8;
  localparam logic [CNTW-1:0] MS_AD_CS   = 5'd9;
  localparam logic [CNTW-1:0] MS_A4_C    = 5'd10;
  localparam logic [CNTW-1:0] MS_A3_S    = 5'd11;
  localparam logic [CNTW-1:0] MS_GAP     = 5'd12;
  localparam logic [CNTW-1:0] MS_DR_K    = 5'd13;
  localparam logic [CNTW-1:0] MS_EV_LAST = 5'd14;
  localparam logic [CNTW-1:0] MS_P       = 5'd15;
  localparam logic [CNTW-1:0] MS_Q       = 5'd16;
  localparam logic [CNTW-1:0] MS_G       = 5'd17;
  localparam logic [CNTW-1:0] MS_IT_LAST = 5'd18;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_Z_X1, OP_Z_X2, OP_Z_RTS, OP_RED, OP_QUAD, OP_CORD,
    OP_SC_FIN, OP_MUL, OP_SAVE_FL, OP_SAVE_FH, OP_START, OP_BISECT,
    OP_DIV_INIT, OP_DIV_STEP, OP_NEWTON, OP_SIDE, OP_RES_ROOT, OP_RES_END,
    OP_RES_NOSIGN, OP_RES_LIMIT
  } azr_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EV_LOAD, S_EV_RED, S_EV_QUAD, S_EV_CORD, S_EV_FIN, S_EV_MUL,
    S_EV_DONE, S_CHECK, S_ITER, S_DECIDE, S_DIV, S_NEWTON, S_STEP_CHK, S_DONE
  } azr_state_t;

  typedef enum logic [1:0] {T_X1, T_X2, T_MID, T_ITER} azr_tag_t;
  typedef enum logic [1:0] {K_ROOT, K_END, K_NOSIGN, K_LIMIT} azr_kind_t;

  typedef struct packed {
    azr_op_t         op;
    logic [CNTW-1:0] idx;
  } azr_cmd_t;

  typedef struct packed {
    logic red_ok;
    logic nosign;
    logic endzero;
    logic bisect;
    logic dx_done;
    logic iter_last;
  } azr_stat_t;

  // atan(2^-i) in degrees, 2^-20 units
  function automatic logic signed [31:0] atan_deg(input logic [CNTW-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 47185920;  5'd1:  v = 27855475;  5'd2:  v = 14718068;
      5'd3:  v = 7471121;   5'd4:  v = 3750058;   5'd5:  v = 1876857;
      5'd6:  v = 938658;    5'd7:  v = 469357;    5'd8:  v = 234682;
      5'd9:  v = 117342;    5'd10: v = 58671;     5'd11: v = 29335;
      5'd12: v = 14668;     5'd13: v = 7334;      5'd14: v = 3667;
      5'd15: v = 1833;      5'd16: v = 917;       5'd17: v = 458;
      5'd18: v = 229;       5'd19: v = 115;       5'd20: v = 57;
      5'd21: v = 29;        5'd22: v = 14;        5'd23: v = 7;
      default: v = 0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/azr_if.sv]
// Request and response channel interfaces of the azimuth root finder.
// No dependencies.
interface azr_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_cos_sq;
  logic signed [31:0] coef_sin_sq;
  logic signed [31:0] coef_cross;
  logic signed [31:0] coef_cos;
  logic signed [31:0] coef_sin;
  logic signed [31:0] coef_const;
  logic signed [25:0] bracket_low;
  logic signed [25:0] bracket_high;
  logic        [24:0] tolerance;
  modport source (output valid, coef_cos_sq, coef_sin_sq, coef_cross, coef_cos, coef_sin,
                  coef_const, bracket_low, bracket_high, tolerance, input ready);
  modport sink (input valid, coef_cos_sq, coef_sin_sq, coef_cross, coef_cos, coef_sin,
                coef_const, bracket_low, bracket_high, tolerance, output ready);
endinterface

interface azr_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [25:0] root_angle;
  logic        [1:0]  status;
  logic        [6:0]  iterations_used;
  modport source (output valid, root_angle, status, iterations_used, input ready);
  modport sink (input valid, root_angle, status, iterations_used, output ready);
endinterface

[rtl/core/azr_ctrl.sv]
// Sequencer of the azimuth root finder: issues one datapath command per cycle.
// Depends on azr_pkg.
module azr_ctrl import azr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  azr_stat_t st,
  output azr_cmd_t  cmd
);

  azr_state_t      state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;
  azr_tag_t        tag, tag_next;
  azr_kind_t       kind, kind_next;
  logic            out_free;
  logic            push;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      tag       <= T_X1;
      kind      <= K_ROOT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      tag   <= tag_next;
      kind  <= kind_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    tag_next   = tag;
    kind_next  = kind;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EV_LOAD;
          tag_next   = T_X1;
        end
      end
      S_EV_LOAD: state_next = S_EV_RED;
      S_EV_RED: begin
        if (st.red_ok) begin
          state_next = S_EV_QUAD;
        end
      end
      S_EV_QUAD: begin
        cnt_next   = '0;
        state_next = S_EV_CORD;
      end
      S_EV_CORD: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNTW'(CORDIC_STEPS - 1)) begin
          state_next = S_EV_FIN;
        end
      end
      S_EV_FIN: begin
        cnt_next   = MS_C_C;
        state_next = S_EV_MUL;
      end
      S_EV_MUL: begin
        cnt_next = cnt + 1'b1;
        if (cnt == MS_EV_LAST) begin
          state_next = S_EV_DONE;
        end
      end
      S_EV_DONE: begin
        unique case (tag)
          T_X1: begin
            tag_next   = T_X2;
            state_next = S_EV_LOAD;
          end
          T_X2: state_next = S_CHECK;
          T_MID: begin
            cnt_next   = MS_P;
            state_next = S_ITER;
          end
          T_ITER: begin
            if (st.iter_last) begin
              kind_next  = K_LIMIT;
              state_next = S_DONE;
            end else begin
              cnt_next   = MS_P;
              state_next = S_ITER;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_CHECK: begin
        if (st.nosign) begin
          kind_next  = K_NOSIGN;
          state_next = S_DONE;
        end else if (st.endzero) begin
          kind_next  = K_END;
          state_next = S_DONE;
        end else begin
          tag_next   = T_MID;
          state_next = S_EV_LOAD;
        end
      end
      S_ITER: begin
        cnt_next = cnt + 1'b1;
        if (cnt == MS_IT_LAST) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.bisect) begin
          state_next = S_STEP_CHK;
        end else begin
          cnt_next   = CNTW'(QB - 1);
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_NEWTON;
        end
      end
      S_NEWTON: state_next = S_STEP_CHK;
      S_STEP_CHK: begin
        if (st.dx_done) begin
          kind_next  = K_ROOT;
          state_next = S_DONE;
        end else begin
          tag_next   = T_ITER;
          state_next = S_EV_LOAD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.idx  = cnt;
    in_ready = 1'b0;
    push     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
        end
      end
      S_EV_LOAD: begin
        unique case (tag)
          T_X1:    cmd.op = OP_Z_X1;
          T_X2:    cmd.op = OP_Z_X2;
          default: cmd.op = OP_Z_RTS;
        endcase
      end
      S_EV_RED:  cmd.op = OP_RED;
      S_EV_QUAD: cmd.op = OP_QUAD;
      S_EV_CORD: cmd.op = OP_CORD;
      S_EV_FIN:  cmd.op = OP_SC_FIN;
      S_EV_MUL:  cmd.op = OP_MUL;
      S_EV_DONE: begin
        unique case (tag)
          T_X1:    cmd.op = OP_SAVE_FL;
          T_X2:    cmd.op = OP_SAVE_FH;
          T_ITER:  cmd.op = OP_SIDE;
          default: cmd.op = OP_NONE;
        endcase
      end
      S_CHECK: begin
        if (!st.nosign && !st.endzero) begin
          cmd.op = OP_START;
        end
      end
      S_ITER:     cmd.op = OP_MUL;
      S_DECIDE:   cmd.op = st.bisect ? OP_BISECT : OP_DIV_INIT;
      S_DIV:      cmd.op = OP_DIV_STEP;
      S_NEWTON:   cmd.op = OP_NEWTON;
      S_STEP_CHK: cmd.op = OP_NONE;
      S_DONE: begin
        if (out_free) begin
          push = 1'b1;
          unique case (kind)
            K_ROOT:   cmd.op = OP_RES_ROOT;
            K_END:    cmd.op = OP_RES_END;
            K_NOSIGN: cmd.op = OP_RES_NOSIGN;
            default:  cmd.op = OP_RES_LIMIT;
          endcase
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

[rtl/core/azr_datapath.sv]
// Datapath of the azimuth root finder: angle reduction, CORDIC, shared
// multiplier, restoring divider, bracket registers and result register.
// Depends on azr_pkg.
module azr_datapath import azr_pkg::*; #(
  parameter int MAX_ITERATIONS = 100,
  parameter int FRAC_BITS      = 16
) (
  input  logic               clk,
  input  azr_cmd_t           cmd,
  output azr_stat_t          st,
  input  logic signed [31:0] coef_cos_sq,
  input  logic signed [31:0] coef_sin_sq,
  input  logic signed [31:0] coef_cross,
  input  logic signed [31:0] coef_cos,
  input  logic signed [31:0] coef_sin,
  input  logic signed [31:0] coef_const,
  input  logic signed [25:0] bracket_low,
  input  logic signed [25:0] bracket_high,
  input  logic        [24:0] tolerance,
  output logic signed [25:0] root_angle,
  output logic        [1:0]  status,
  output logic        [6:0]  iterations_used
);

  localparam int SHL = (ANG_BITS >= FRAC_BITS) ? ANG_BITS - FRAC_BITS : 0;
  localparam int SHR = (FRAC_BITS > ANG_BITS) ? FRAC_BITS - ANG_BITS : 0;
  localparam int ZW  = AW + 2 + SHL;
  localparam int JW  = $clog2(MAX_ITERATIONS + 2);
  localparam logic signed [ZW-1:0] Z_FULL    = ZW'(360 * (2 ** ANG_BITS));
  localparam logic signed [ZW-1:0] Z_HALF    = ZW'(180 * (2 ** ANG_BITS));
  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90 * (2 ** ANG_BITS));

  logic signed [31:0]   a0, a1, a2, a3, a4, a5;
  logic signed [AW-1:0] x1, x2;
  logic        [24:0]   tol;
  logic signed [ZW-1:0] z;
  logic                 neg;
  logic signed [CW-1:0] cx, cy, c, s, cc, ss, cs;
  logic signed [VW-1:0] f, dr, df, fl, fh;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] xl, xh, rts, dx, dxold;
  logic                 p_pos, p_neg, q_pos, q_neg, big;
  logic        [DVW-1:0] rem, den;
  logic        [QB-1:0] quo;
  logic        [JW-1:0] j;

  // combinational helpers
  logic signed [AW-1:0] ang_sel;
  logic signed [ZW-1:0] z_ext, z_init, at;
  logic signed [MW-1:0] ma, mb;
  logic signed [32:0]   a_diff;
  logic signed [CW:0]   cc_ss;
  logic signed [VW-1:0] p30, p29;
  logic signed [CW-1:0] c30;
  logic signed [PW-1:0] pq;
  logic        [PW-1:0] abs_prod, lhs;
  logic        [VW-1:0] abs_f, abs_df;
  logic        [DVW-1:0] trial;
  logic signed [AW-1:0] qv, dx_new, half_gap, mid, gap_abs;
  logic        [AW-1:0] dx_abs;

  always_comb begin
    case (cmd.op)
      OP_Z_X1: ang_sel = x1;
      OP_Z_X2: ang_sel = x2;
      default: ang_sel = rts;
    endcase
    z_ext  = ZW'(ang_sel);
    z_init = (z_ext <<< SHL) >>> SHR;
    at     = ZW'(atan_deg(cmd.idx));
  end

  assign a_diff = 33'(a1) - 33'(a0);
  assign cc_ss  = (CW+1)'(cc) - (CW+1)'(ss);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.idx)
      MS_C_C:   begin ma = MW'(c);      mb = MW'(c);      end
      MS_S_S:   begin ma = MW'(s);      mb = MW'(s);      end
      MS_C_S:   begin ma = MW'(c);      mb = MW'(s);      end
      MS_A0_CC: begin ma = MW'(a0);     mb = MW'(cc);     end
      MS_A1_SS: begin ma = MW'(a1);     mb = MW'(ss);     end
      MS_A2_CS: begin ma = MW'(a2);     mb = MW'(cs);     end
      MS_A3_C:  begin ma = MW'(a3);     mb = MW'(c);      end
      MS_A4_S:  begin ma = MW'(a4);     mb = MW'(s);      end
      MS_A2_D:  begin ma = MW'(a2);     mb = MW'(cc_ss);  end
      MS_AD_CS: begin ma = MW'(a_diff); mb = MW'(cs);     end
      MS_A4_C:  begin ma = MW'(a4);     mb = MW'(c);      end
      MS_A3_S:  begin ma = MW'(a3);     mb = MW'(s);      end
      MS_DR_K:  begin ma = MW'(dr);     mb = MW'(DEG_TO_RAD); end
      MS_P:     begin ma = MW'(rts - xh); mb = MW'(df);   end
      MS_Q:     begin ma = MW'(rts - xl); mb = MW'(df);   end
      MS_G:     begin ma = MW'(dxold);  mb = MW'(df);     end
      default:  begin ma = '0;          mb = '0;          end
    endcase
  end

  always_comb begin
    p30      = VW'(prod >>> 30);
    p29      = VW'(prod >>> 29);
    c30      = CW'(prod >>> 30);
    pq       = prod - (PW'(f) <<< FRAC_BITS);
    abs_prod = prod[PW-1] ? PW'(-prod) : PW'(prod);
    abs_f    = f[VW-1] ? VW'(-f) : VW'(f);
    abs_df   = df[VW-1] ? VW'(-df) : VW'(df);
    lhs      = PW'(abs_f) << (FRAC_BITS + 1);
    trial    = den << cmd.idx;
    qv       = AW'(quo);
    if (df == '0) begin
      dx_new = '0;
    end else if (f[VW-1] ^ df[VW-1]) begin
      dx_new = -qv;
    end else begin
      dx_new = qv;
    end
    half_gap = (xh - xl) >>> 1;
    mid      = (x1 + x2) >>> 1;
    gap_abs  = (x2 >= x1) ? (x2 - x1) : (x1 - x2);
    dx_abs   = dx[AW-1] ? AW'(-dx) : AW'(dx);
  end

  always_comb begin
    st.red_ok    = !(z >= Z_HALF) && !(z < -Z_HALF);
    st.nosign    = (fl > 0 && fh > 0) || (fl < 0 && fh < 0);
    st.endzero   = (fl == '0) || (fh == '0);
    st.bisect    = (p_pos && q_pos) || (p_neg && q_neg) || big;
    st.dx_done   = (dx == '0) || (dx_abs < AW'(tol));
    st.iter_last = (j == JW'(MAX_ITERATIONS));
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        a0  <= coef_cos_sq;
        a1  <= coef_sin_sq;
        a2  <= coef_cross;
        a3  <= coef_cos;
        a4  <= coef_sin;
        a5  <= coef_const;
        x1  <= AW'(bracket_low);
        x2  <= AW'(bracket_high);
        tol <= tolerance;
      end
      OP_Z_X1, OP_Z_X2, OP_Z_RTS: z <= z_init;
      OP_RED: begin
        if (z >= Z_HALF) begin
          z <= z - Z_FULL;
        end else if (z < -Z_HALF) begin
          z <= z + Z_FULL;
        end
      end
      OP_QUAD: begin
        if (z > Z_QUARTER) begin
          z   <= z - Z_HALF;
          neg <= 1'b1;
        end else if (z < -Z_QUARTER) begin
          z   <= z + Z_HALF;
          neg <= 1'b1;
        end else begin
          neg <= 1'b0;
        end
        cx <= CW'(CORDIC_GAIN);
        cy <= '0;
      end
      OP_CORD: begin
        if (!z[ZW-1]) begin
          cx <= cx - (cy >>> cmd.idx);
          cy <= cy + (cx >>> cmd.idx);
          z  <= z - at;
        end else begin
          cx <= cx + (cy >>> cmd.idx);
          cy <= cy - (cx >>> cmd.idx);
          z  <= z + at;
        end
      end
      OP_SC_FIN: begin
        c <= neg ? -cx : cx;
        s <= neg ? -cy : cy;
      end
      OP_MUL: begin
        prod <= ma * mb;
        // fold in the product issued one step earlier
        case (cmd.idx)
          MS_S_S:     cc <= c30;
          MS_C_S:     ss <= c30;
          MS_A0_CC:   cs <= c30;
          MS_A1_SS:   f  <= p30;
          MS_A2_CS,
          MS_A3_C,
          MS_A4_S:    f  <= f + p30;
          MS_A2_D:    f  <= f + p30 + VW'(a5);
          MS_AD_CS:   dr <= p30;
          MS_A4_C:    dr <= dr + p29;
          MS_A3_S:    dr <= dr + p30;
          MS_GAP:     dr <= dr - p30;
          MS_EV_LAST: df <= p30;
          MS_Q: begin
            p_pos <= (pq > 0);
            p_neg <= pq[PW-1];
          end
          MS_G: begin
            q_pos <= (pq > 0);
            q_neg <= pq[PW-1];
          end
          MS_IT_LAST: big <= (lhs > abs_prod);
          default: ;
        endcase
      end
      OP_SAVE_FL: fl <= f;
      OP_SAVE_FH: fh <= f;
      OP_START: begin
        if (fl < 0) begin
          xl <= x1;
          xh <= x2;
        end else begin
          xl <= x2;
          xh <= x1;
        end
        rts   <= mid;
        dx    <= gap_abs;
        dxold <= gap_abs;
        j     <= JW'(1);
      end
      OP_BISECT: begin
        dxold <= dx;
        dx    <= half_gap;
        rts   <= xl + half_gap;
      end
      OP_DIV_INIT: begin
        dxold <= dx;
        rem   <= DVW'(abs_f) << FRAC_BITS;
        den   <= DVW'(abs_df);
        quo   <= '0;
      end
      OP_DIV_STEP: begin
        if (rem >= trial) begin
          rem           <= rem - trial;
          quo[cmd.idx]  <= 1'b1;
        end
      end
      OP_NEWTON: begin
        dx  <= dx_new;
        rts <= rts - dx_new;
      end
      OP_SIDE: begin
        if (f < 0) begin
          xl <= rts;
        end else begin
          xh <= rts;
        end
        j <= j + 1'b1;
      end
      OP_RES_ROOT: begin
        root_angle      <= rts[25:0];
        status          <= ST_FOUND;
        iterations_used <= 7'(j);
      end
      OP_RES_END: begin
        root_angle      <= (fl == '0) ? x1[25:0] : x2[25:0];
        status          <= ST_FOUND;
        iterations_used <= '0;
      end
      OP_RES_NOSIGN: begin
        root_angle      <= '0;
        status          <= ST_NOSIGN;
        iterations_used <= '0;
      end
      OP_RES_LIMIT: begin
        root_angle      <= '0;
        status          <= ST_LIMIT;
        iterations_used <= 7'(MAX_ITERATIONS);
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/azimuth_root_newton_bisection.sv]
// Top level of the azimuth root finder: sequencer plus datapath.
// Depends on azr_pkg, azr_req_if, azr_rsp_if, azr_ctrl and azr_datapath.
//
// Usage:
//  - req carries one word: six Q16.16 coefficients of
//    f(t) = c2 cos^2 + s2 sin^2 + cx cos sin + c1 cos + s1 sin + k (t in degrees),
//    a bracket and a tolerance. rsp returns root_angle, status, iterations_used.
//  - One word is in flight at a time; req.ready is high only while the
//    sequencer is idle. A finished result sits in the output register, so the
//    next request is taken even while rsp is stalled.
//  - Each evaluation of f and f' runs a reduction (one 360 degree wrap at a
//    time), 24 CORDIC steps and 15 steps of the one shared multiplier. Both
//    bracket ends are evaluated first.
//  - Each refinement iteration runs the shared multiplier and a decision, then
//    either a bisection or a restoring divide of the 28 quotient bits for the
//    Newton step, and one evaluation.
//  - If rsp.ready is low when a result is done, the sequencer holds it until
//    the output register frees up.
//  - rst (synchronous) returns the sequencer to idle and drops rsp.valid.
module azimuth_root_newton_bisection import azr_pkg::*; #(
  parameter int MAX_ITERATIONS = 100,
  parameter int FRAC_BITS      = 16
) (
  input logic clk,
  input logic rst,
  azr_req_if.sink   req,
  azr_rsp_if.source rsp
);

  azr_cmd_t  cmd;
  azr_stat_t st;

  // sequencer: one command per cycle into the datapath
  azr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath holds the item, the search state and the result register
  azr_datapath #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .FRAC_BITS      (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .st              (st),
    .coef_cos_sq     (req.coef_cos_sq),
    .coef_sin_sq     (req.coef_sin_sq),
    .coef_cross      (req.coef_cross),
    .coef_cos        (req.coef_cos),
    .coef_sin        (req.coef_sin),
    .coef_const      (req.coef_const),
    .bracket_low     (req.bracket_low),
    .bracket_high    (req.bracket_high),
    .tolerance       (req.tolerance),
    .root_angle      (rsp.root_angle),
    .status          (rsp.status),
    .iterations_used (rsp.iterations_used)
  );

endmodule
